[hw/rtl/lmc_pkg.sv]
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types, opcodes and decode helpers of the Little Man Computer core.
// ----------------------------------------------------------------------------
package lmc_pkg;

  localparam int LMC_MAILBOXES = 100;
  localparam int PC_W          = 7;
  localparam int WORD_W        = 32;

  // hundreds digit of an instruction word
  localparam logic [3:0] OP_HLT = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_STA = 4'd3;
  localparam logic [3:0] OP_LDA = 4'd5;
  localparam logic [3:0] OP_BRA = 4'd6;
  localparam logic [3:0] OP_BRZ = 4'd7;
  localparam logic [3:0] OP_BRP = 4'd8;
  localparam logic [3:0] OP_IO  = 4'd9;

  // address field of the I/O group
  localparam logic [PC_W-1:0] IO_INP = 7'd1;
  localparam logic [PC_W-1:0] IO_OUT = 7'd2;

  localparam logic [9:0] WORD_MAX = 10'd999;

  typedef struct packed {
    logic                     mode;
    logic [PC_W-1:0]          load_address;
    logic signed [WORD_W-1:0] load_value;
    logic signed [WORD_W-1:0] inp_value;
  } lmc_item_t;

  typedef struct packed {
    logic              bad;
    logic [3:0]        op;
    logic [PC_W-1:0]   addr;
    logic              oper_ok;
  } lmc_instr_t;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [PC_W-1:0]   pc;
    logic              halt;
    logic              fault;
  } lmc_state_t;

  typedef struct packed {
    lmc_state_t        nxt;
    logic              wr_en;
    logic [PC_W-1:0]   wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              outv;
    logic [WORD_W-1:0] outval;
  } lmc_exec_t;

  // floor(w / 100) for w <= 999, by reciprocal multiply
  function automatic logic [3:0] lmc_hundreds(input logic [9:0] w);
    logic [15:0] p;
    p = {6'd0, w} * 16'd41;
    return p[15:12];
  endfunction

  // w mod 100, given the hundreds digit
  function automatic logic [PC_W-1:0] lmc_low_digits(input logic [9:0] w,
                                                     input logic [3:0] op);
    logic [9:0] r;
    r = w - ({6'd0, op} * 10'd100);
    return r[PC_W-1:0];
  endfunction

endpackage

[hw/rtl/lmc_in_if.sv]
// ----------------------------------------------------------------------------
// lmc_in_if
// Input channel: one load or step word per handshake.
// ----------------------------------------------------------------------------
interface lmc_in_if import lmc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [PC_W-1:0]          load_address;
  logic signed [WORD_W-1:0] load_value;
  logic signed [WORD_W-1:0] inp_value;

  modport source (output valid, mode, load_address, load_value, inp_value,
                  input ready);
  modport sink   (input valid, mode, load_address, load_value, inp_value,
                  output ready);
endinterface

[hw/rtl/lmc_out_if.sv]
// ----------------------------------------------------------------------------
// lmc_out_if
// Result channel: one status word per accepted input word.
// ----------------------------------------------------------------------------
interface lmc_out_if import lmc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_value;
  logic [PC_W-1:0]          next_pc;
  logic                     halted;
  logic                     fault;

  modport source (output valid, out_valid, out_value, next_pc, halted, fault,
                  input ready);
  modport sink   (input valid, out_valid, out_value, next_pc, halted, fault,
                  output ready);
endinterface

[hw/rtl/lmc_mailbox_ram.sv]
// ----------------------------------------------------------------------------
// lmc_mailbox_ram
// Mailbox store: one write port, one registered read port, write-first.
// ----------------------------------------------------------------------------
module lmc_mailbox_ram import lmc_pkg::*; #(
  parameter int MAILBOXES = LMC_MAILBOXES
) (
  input  logic              clk,
  input  logic              we,
  input  logic [PC_W-1:0]   wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [PC_W-1:0]   rd_addr,
  output logic [WORD_W-1:0] rd_data_r
);

  localparam int ADDR_W = $clog2(MAILBOXES);

  logic [WORD_W-1:0] mem [MAILBOXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
  end

  // forward a same-cycle write so a fetch right after STA sees new data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (we && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

[hw/rtl/lmc_exec_unit.sv]
// ----------------------------------------------------------------------------
// lmc_exec_unit
// Execute stage: applies one decoded instruction or load to the core state.
// ----------------------------------------------------------------------------
module lmc_exec_unit import lmc_pkg::*; #(
  parameter int MAILBOXES = LMC_MAILBOXES
) (
  input  lmc_item_t         item,
  input  lmc_instr_t        instr,
  input  logic [WORD_W-1:0] oper,
  input  lmc_state_t        cur,
  output lmc_exec_t         res
);

  localparam logic [PC_W-1:0] LIMIT = PC_W'(MAILBOXES);
  localparam logic [PC_W-1:0] LAST  = PC_W'(MAILBOXES - 1);

  logic [PC_W-1:0]   pc_adv;
  logic [WORD_W-1:0] opnd;
  logic              in_range;

  assign pc_adv   = (cur.pc == LAST) ? '0 : cur.pc + 1'b1;
  assign opnd     = instr.oper_ok ? oper : '0;
  assign in_range = instr.addr < LIMIT;

  always_comb begin
    res         = '0;
    res.nxt     = cur;
    res.wr_addr = instr.addr;
    res.wr_data = cur.acc;
    if (!item.mode) begin
      if (item.load_address < LIMIT) begin
        res.wr_en   = 1'b1;
        res.wr_addr = item.load_address;
        res.wr_data = item.load_value;
      end
    end else if (!cur.halt) begin
      if (instr.bad) begin
        res.nxt.fault = 1'b1;
        res.nxt.halt  = 1'b1;
      end else begin
        unique case (instr.op)
          OP_HLT: begin
            res.nxt.halt = 1'b1;
            res.nxt.pc   = pc_adv;
          end
          OP_IO: begin
            if (instr.addr == IO_INP) begin
              res.nxt.acc = item.inp_value;
              res.nxt.pc  = pc_adv;
            end else if (instr.addr == IO_OUT) begin
              res.outv    = 1'b1;
              res.outval  = cur.acc;
              res.nxt.pc  = pc_adv;
            end else begin
              res.nxt.fault = 1'b1;
              res.nxt.halt  = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_STA, OP_LDA, OP_BRA, OP_BRZ, OP_BRP: begin
            if (!in_range) begin
              res.nxt.fault = 1'b1;
              res.nxt.halt  = 1'b1;
            end else begin
              res.nxt.pc = pc_adv;
              if (instr.op == OP_ADD) begin
                res.nxt.acc = cur.acc + opnd;
              end else if (instr.op == OP_SUB) begin
                res.nxt.acc = cur.acc - opnd;
              end else if (instr.op == OP_STA) begin
                res.wr_en = 1'b1;
              end else if (instr.op == OP_LDA) begin
                if (instr.oper_ok) begin
                  res.nxt.acc = oper;
                end else begin
                  res.nxt.fault = 1'b1;
                  res.nxt.halt  = 1'b1;
                  res.nxt.pc    = cur.pc;
                end
              end else if (instr.op == OP_BRA) begin
                res.nxt.pc = instr.addr;
              end else if (instr.op == OP_BRZ) begin
                if (cur.acc == '0) res.nxt.pc = instr.addr;
              end else begin
                if (!cur.acc[WORD_W-1]) res.nxt.pc = instr.addr;
              end
            end
          end
          default: begin
            res.nxt.fault = 1'b1;
            res.nxt.halt  = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

[hw/rtl/lmc_instruction_executor_top.sv]
// ----------------------------------------------------------------------------
// lmc_instruction_executor_top
// Little Man Computer core: loads mailboxes and steps one instruction a word.
// ----------------------------------------------------------------------------
// The input word, its decoded instruction and then the result word (once the
// output is free) are registered in turn; a new word is taken only while idle
// or as the step executes. The instruction fetch and the operand read share the single read port of the mailbox RAM.
// Reset (rst_n low, synchronous): clears accumulator, PC, halt and fault
// flags, the written marks and the handshake state. RAM contents are kept.
module lmc_instruction_executor_top import lmc_pkg::*; #(
  parameter int MAILBOXES = LMC_MAILBOXES
) (
  input logic       clk,
  input logic       rst_n,
  lmc_in_if.sink    in_ch,
  lmc_out_if.source out_ch
);

  localparam int              ADDR_W = $clog2(MAILBOXES);
  localparam logic [PC_W-1:0] LIMIT  = PC_W'(MAILBOXES);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_EXEC   = 2'd2;

  logic [1:0]           ph_r, ph_nxt;
  lmc_item_t            item_r;
  logic                 fetch_ok_r;
  lmc_instr_t           instr_r, dec;
  lmc_state_t           st_r;
  logic [MAILBOXES-1:0] written_r;
  logic                 out_valid_r;
  logic                 out_outv_r;
  logic [WORD_W-1:0]    out_value_r;
  logic [PC_W-1:0]      out_pc_r;
  logic                 out_halt_r;
  logic                 out_fault_r;

  logic [WORD_W-1:0]    rd_data;
  logic [WORD_W-1:0]    word;
  logic [PC_W-1:0]      fetch_addr;
  logic [PC_W-1:0]      rd_addr;
  logic                 fetch_ok;
  logic                 rd_en;
  logic                 out_free;
  logic                 in_fire;
  logic                 exec_fire;
  logic                 wr_fire;
  lmc_exec_t            ex;
  lmc_item_t            in_item;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign exec_fire = (ph_r == PH_EXEC) && out_free;
  assign wr_fire   = exec_fire && ex.wr_en;
  assign in_ch.ready = (ph_r == PH_IDLE) || exec_fire;
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign in_item.mode         = in_ch.mode;
  assign in_item.load_address = in_ch.load_address;
  assign in_item.load_value   = in_ch.load_value;
  assign in_item.inp_value    = in_ch.inp_value;

  // fetch at the PC the current step leaves behind
  assign fetch_addr = (ph_r == PH_EXEC) ? ex.nxt.pc : st_r.pc;
  assign fetch_ok   = (fetch_addr < LIMIT) &&
                      (written_r[fetch_addr[ADDR_W-1:0]] ||
                       (wr_fire && (ex.wr_addr == fetch_addr)));

  // decode the fetched word; an unwritten or out-of-range fetch is HLT
  assign word      = fetch_ok_r ? rd_data : '0;
  assign dec.bad   = (word[WORD_W-1:10] != '0) || (word[9:0] > WORD_MAX);
  assign dec.op    = lmc_hundreds(word[9:0]);
  assign dec.addr  = lmc_low_digits(word[9:0], dec.op);
  assign dec.oper_ok = (dec.addr < LIMIT) && written_r[dec.addr[ADDR_W-1:0]];

  assign rd_en   = (ph_r == PH_DECODE) || in_fire;
  assign rd_addr = (ph_r == PH_DECODE) ? dec.addr : fetch_addr;

  lmc_mailbox_ram #(
    .MAILBOXES (MAILBOXES)
  ) u_ram (
    .clk       (clk),
    .we        (wr_fire),
    .wr_addr   (ex.wr_addr),
    .wr_data   (ex.wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  lmc_exec_unit #(
    .MAILBOXES (MAILBOXES)
  ) u_exec (
    .item  (item_r),
    .instr (instr_r),
    .oper  (rd_data),
    .cur   (st_r),
    .res   (ex)
  );

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (in_fire) ph_nxt = PH_DECODE;
      end
      PH_DECODE: begin
        ph_nxt = PH_EXEC;
      end
      PH_EXEC: begin
        if (in_fire)        ph_nxt = PH_DECODE;
        else if (exec_fire) ph_nxt = PH_IDLE;
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      st_r        <= '0;
      written_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (exec_fire) begin
        st_r        <= ex.nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_fire) begin
        written_r[ex.wr_addr[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r     <= in_item;
      fetch_ok_r <= fetch_ok;
    end
    if (ph_r == PH_DECODE) begin
      instr_r <= dec;
    end
    if (exec_fire) begin
      out_outv_r  <= ex.outv;
      out_value_r <= ex.outval;
      out_pc_r    <= ex.nxt.pc;
      out_halt_r  <= ex.nxt.halt;
      out_fault_r <= ex.nxt.fault;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_valid = out_outv_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.next_pc   = out_pc_r;
  assign out_ch.halted    = out_halt_r;
  assign out_ch.fault     = out_fault_r;

`ifndef SYNTHESIS
  a_fault_halts : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fault |-> st_r.halt)
    else $error("fault flag set without halt flag");

  a_pc_range : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pc < LIMIT)
    else $error("program counter beyond the mailbox range");

  a_out_from_exec : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_fire))
    else $error("result raised without an execute step");

  a_halt_freezes : assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && item_r.mode && st_r.halt) |=>
      (st_r.pc == $past(st_r.pc)) && (st_r.acc == $past(st_r.acc)))
    else $error("state changed by a step while halted");

  a_marks_hold : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((written_r & $past(written_r)) == $past(written_r)))
    else $error("written mark cleared outside reset");
`endif

endmodule
